// ===== hdl/mlft_pkg.sv =====
// ----------------------------------------------------------------------------
// MAC learning forwarding table package
// Widths, codes and the types shared by the table's modules.
// ----------------------------------------------------------------------------
package mlft_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int MAC_W  = 48;
  localparam int IP_W   = 32;
  localparam int PORT_W = 16;
  localparam int EP_W   = IP_W + PORT_W;
  localparam int ACT_W  = 2;

  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  localparam logic [ACT_W-1:0] ACT_UNICAST = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BCAST   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DROP    = 2'd2;

  typedef struct packed {
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  src_mac;
    logic [IP_W-1:0]   src_ip;
    logic [PORT_W-1:0] src_udp_port;
  } req_t;

  typedef struct packed {
    logic [IP_W-1:0]   out_ip;
    logic [PORT_W-1:0] out_udp_port;
    logic [ACT_W-1:0]  action;
    logic              learn_full;
    logic              last_result;
  } rsp_t;

  typedef struct packed {
    logic cmp;
    logic learn;
    logic append;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    cell_ctl_t cells;
    logic      grp;
  } ring_ctl_t;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [EP_W-1:0]  ep;
    logic             any_hit;
  } ring_stat_t;

endpackage

// ===== hdl/mlft_cell.sv =====
// ----------------------------------------------------------------------------
// MAC table cell
// Holds one station entry, compares it with the source key, takes learned
// data and takes the entry of the next cell of the ring when shifting.
// ----------------------------------------------------------------------------
module mlft_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  mlft_pkg::cell_ctl_t        ctl,
  input  logic                       occ,
  input  logic                       sel,
  input  logic [mlft_pkg::MAC_W-1:0] key_mac,
  input  logic [mlft_pkg::EP_W-1:0]  new_ep,
  input  logic [mlft_pkg::MAC_W-1:0] nb_mac,
  input  logic [mlft_pkg::EP_W-1:0]  nb_ep,
  output logic [mlft_pkg::MAC_W-1:0] mac,
  output logic [mlft_pkg::EP_W-1:0]  ep,
  output logic                       hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.cmp) begin
      hit <= occ && (mac == key_mac);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      mac <= nb_mac;
      ep  <= nb_ep;
    end else if (ctl.learn && hit) begin
      ep <= new_ep;
    end else if (ctl.append && sel) begin
      mac <= key_mac;
      ep  <= new_ep;
    end
  end

endmodule

// ===== hdl/mlft_ring.sv =====
// ----------------------------------------------------------------------------
// MAC table ring
// A ring of table cells with a registered reduction of the source match
// bits; cell zero is the head that the controller examines.
// ----------------------------------------------------------------------------
module mlft_ring #(
  parameter int DEPTH = mlft_pkg::TABLE_DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mlft_pkg::ring_ctl_t        ctl,
  input  logic [CNT_W-1:0]           count,
  input  logic [mlft_pkg::MAC_W-1:0] key_mac,
  input  logic [mlft_pkg::EP_W-1:0]  new_ep,
  output mlft_pkg::ring_stat_t       stat
);

  localparam int NGRP = (DEPTH + 7) / 8;

  logic [mlft_pkg::MAC_W-1:0] mac [DEPTH];
  logic [mlft_pkg::EP_W-1:0]  ep  [DEPTH];
  logic [DEPTH-1:0]           hit;
  logic [NGRP-1:0]            grp;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mlft_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl.cells),
      .occ     (count > CNT_W'(i)),
      .sel     (count == CNT_W'(i)),
      .key_mac (key_mac),
      .new_ep  (new_ep),
      .nb_mac  (mac[(i + 1) % DEPTH]),
      .nb_ep   (ep[(i + 1) % DEPTH]),
      .mac     (mac[i]),
      .ep      (ep[i]),
      .hit     (hit[i])
    );
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    localparam int LO = g * 8;
    localparam int HI = (g * 8 + 7 < DEPTH) ? g * 8 + 7 : DEPTH - 1;
    always_ff @(posedge clk) begin
      if (rst) begin
        grp[g] <= 1'b0;
      end else if (ctl.grp) begin
        grp[g] <= |hit[HI:LO];
      end
    end
  end

  assign stat.mac     = mac[0];
  assign stat.ep      = ep[0];
  assign stat.any_hit = |grp;

endmodule

// ===== hdl/mac_learning_forwarding_table_unit.sv =====
// ----------------------------------------------------------------------------
// MAC learning forwarding table
// Each request passes through compare, reduce and learn, then the ring
// rotates once through all TABLE_DEPTH cells, one cell per cycle while no
// stalled result holds it, and a final state closes the frame. A result is
// held until the next target is found; a stalled result pauses the ring.
// Synchronous reset clears the entry count and all control state.
// ----------------------------------------------------------------------------
module mac_learning_forwarding_table_unit #(
  parameter int TABLE_DEPTH = mlft_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mlft_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mlft_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_GRP,
    S_LEARN,
    S_ROT,
    S_FIN
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           step;
  logic [mlft_pkg::MAC_W-1:0] dst;
  logic [mlft_pkg::MAC_W-1:0] src;
  logic [mlft_pkg::EP_W-1:0]  new_ep;
  logic                       bcast;
  logic                       full;
  logic                       pend_valid;
  mlft_pkg::rsp_t             pend;

  mlft_pkg::ring_ctl_t  ctl;
  mlft_pkg::ring_stat_t stat;

  logic           table_full;
  logic           head_occ;
  logic           target;
  logic           push_ok;
  logic           advance;
  logic           rsp_load;
  mlft_pkg::rsp_t fin_rsp;

  always_comb begin
    table_full = (count == CNT_W'(TABLE_DEPTH));
    head_occ   = (step < count);
    target     = head_occ && (bcast ? (stat.mac != src) : (stat.mac == dst));
    push_ok    = !rsp_valid || rsp_ready;
    advance    = !target || !pend_valid || push_ok;
    rsp_load   = ((state == S_ROT) && advance && target && pend_valid) ||
                 ((state == S_FIN) && push_ok);

    fin_rsp             = pend;
    fin_rsp.last_result = 1'b1;
    if (!pend_valid) begin
      fin_rsp.out_ip       = '0;
      fin_rsp.out_udp_port = '0;
      fin_rsp.action       = mlft_pkg::ACT_DROP;
      fin_rsp.learn_full   = full;
    end

    ctl.cells.cmp    = (state == S_CMP);
    ctl.grp          = (state == S_GRP);
    ctl.cells.learn  = (state == S_LEARN) && stat.any_hit;
    ctl.cells.append = (state == S_LEARN) && !stat.any_hit && !table_full;
    ctl.cells.shift  = (state == S_ROT) && advance;
  end

  assign req_ready = (state == S_IDLE);

  mlft_ring #(
    .DEPTH (TABLE_DEPTH),
    .CNT_W (CNT_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .count   (count),
    .key_mac (src),
    .new_ep  (new_ep),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      step       <= '0;
      full       <= 1'b0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            dst    <= req.dst_mac;
            src    <= req.src_mac;
            new_ep <= {req.src_ip, req.src_udp_port};
            bcast  <= (req.dst_mac == mlft_pkg::BCAST_MAC);
            state  <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_GRP;
        end
        S_GRP: begin
          state <= S_LEARN;
        end
        S_LEARN: begin
          full <= !stat.any_hit && table_full;
          if (ctl.cells.append) begin
            count <= count + CNT_W'(1);
          end
          step  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (advance) begin
            if (target) begin
              if (pend_valid) begin
                rsp <= pend;
              end
              pend.out_ip       <= stat.ep[mlft_pkg::EP_W-1:mlft_pkg::PORT_W];
              pend.out_udp_port <= stat.ep[mlft_pkg::PORT_W-1:0];
              pend.action       <= bcast ? mlft_pkg::ACT_BCAST : mlft_pkg::ACT_UNICAST;
              pend.learn_full   <= full;
              pend.last_result  <= 1'b0;
              pend_valid        <= 1'b1;
            end
            if (step == CNT_W'(TABLE_DEPTH - 1)) begin
              state <= S_FIN;
            end else begin
              step <= step + CNT_W'(1);
            end
          end
        end
        S_FIN: begin
          if (push_ok) begin
            rsp        <= fin_rsp;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/mlft_checker.sv =====
// ----------------------------------------------------------------------------
// MAC learning forwarding table checker
// Port-level properties of the table, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mlft_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input mlft_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("Stalled response changed.");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("A second request was taken while one is in progress.");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action == mlft_pkg::ACT_DROP |->
      rsp.out_ip == '0 && rsp.out_udp_port == '0 && rsp.last_result)
    else $error("Drop response carries an endpoint or is not the last one.");

  a_no_bad_action: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.action == mlft_pkg::ACT_UNICAST ||
      rsp.action == mlft_pkg::ACT_BCAST || rsp.action == mlft_pkg::ACT_DROP)
    else $error("Response carries an undefined action.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("Response valid right after reset.");

endmodule

bind mac_learning_forwarding_table_unit mlft_checker u_mlft_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning forwarding table testbench
// Sends frame requests with random gaps while the response side stalls at
// random. A scoreboard keeps its own copy of the station table, predicts the
// forward, flood and drop responses of each accepted request, and compares
// every accepted response in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH         = mlft_pkg::TABLE_DEPTH_DEF;
  localparam int RANDOM_FRAMES = 147;
  localparam int CALM_FRAMES   = 30;
  localparam int CYCLE_LIMIT   = 1000000;

  class station_scoreboard;
    logic [mlft_pkg::MAC_W-1:0] station_mac [DEPTH];
    logic [mlft_pkg::EP_W-1:0]  station_ep [DEPTH];
    int unsigned                station_count = 0;
    mlft_pkg::rsp_t             pending_rsp[$];
    int unsigned                errors = 0;
    int unsigned                frames = 0;
    int unsigned                checked = 0;
    int unsigned                floods = 0;
    int unsigned                refused = 0;

    function int find_station(logic [mlft_pkg::MAC_W-1:0] mac);
      for (int i = 0; i < station_count; i++) begin
        if (station_mac[i] == mac) return i;
      end
      return -1;
    endfunction

    function mlft_pkg::rsp_t make_rsp(logic [mlft_pkg::EP_W-1:0] ep,
                                      logic [mlft_pkg::ACT_W-1:0] act, logic full);
      mlft_pkg::rsp_t r;
      r.out_ip       = ep[mlft_pkg::EP_W-1:mlft_pkg::PORT_W];
      r.out_udp_port = ep[mlft_pkg::PORT_W-1:0];
      r.action       = act;
      r.learn_full   = full;
      r.last_result  = 1'b0;
      return r;
    endfunction

    function void note_request(mlft_pkg::req_t r);
      mlft_pkg::rsp_t            frame_rsp[$];
      logic [mlft_pkg::EP_W-1:0] ep;
      logic                      full;
      int                        slot;
      ep = {r.src_ip, r.src_udp_port};
      full = 1'b0;
      frames++;
      slot = find_station(r.src_mac);
      if (slot >= 0) begin
        station_ep[slot] = ep;
      end else if (station_count < DEPTH) begin
        station_mac[station_count] = r.src_mac;
        station_ep[station_count]  = ep;
        station_count++;
      end else begin
        full = 1'b1;
        refused++;
      end
      if (r.dst_mac == mlft_pkg::BCAST_MAC) begin
        floods++;
        for (int i = 0; i < station_count; i++) begin
          if (station_mac[i] != r.src_mac) begin
            frame_rsp.push_back(make_rsp(station_ep[i], mlft_pkg::ACT_BCAST, full));
          end
        end
      end else begin
        slot = find_station(r.dst_mac);
        if (slot >= 0) begin
          frame_rsp.push_back(make_rsp(station_ep[slot], mlft_pkg::ACT_UNICAST, full));
        end
      end
      if (frame_rsp.size() == 0) frame_rsp.push_back(make_rsp('0, mlft_pkg::ACT_DROP, full));
      frame_rsp[frame_rsp.size()-1].last_result = 1'b1;
      foreach (frame_rsp[k]) pending_rsp.push_back(frame_rsp[k]);
    endfunction

    function void check_field(string name, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_response(mlft_pkg::rsp_t got);
      mlft_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("response 0x%0h arrived with nothing expected", got);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      checked++;
      check_field("out_ip", 48'(want.out_ip), 48'(got.out_ip));
      check_field("out_udp_port", 48'(want.out_udp_port), 48'(got.out_udp_port));
      check_field("action", 48'(want.action), 48'(got.action));
      check_field("learn_full", 48'(want.learn_full), 48'(got.learn_full));
      check_field("last_result", 48'(want.last_result), 48'(got.last_result));
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  mlft_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_ready;
  mlft_pkg::rsp_t rsp;

  station_scoreboard sb = new();
  bit                calm = 1'b0;
  int unsigned       cycles = 0;
  int unsigned       stall_left = 0;

  mac_learning_forwarding_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_ready = 1'b0;
        stall_left = $urandom_range(0, 13);
      end else begin
        rsp_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  function automatic mlft_pkg::req_t frame(logic [mlft_pkg::MAC_W-1:0] dst,
                                           logic [mlft_pkg::MAC_W-1:0] src,
                                           logic [mlft_pkg::IP_W-1:0] ip,
                                           logic [mlft_pkg::PORT_W-1:0] port);
    mlft_pkg::req_t r;
    r.dst_mac      = dst;
    r.src_mac      = src;
    r.src_ip       = ip;
    r.src_udp_port = port;
    return r;
  endfunction

  task automatic send_frame(input mlft_pkg::req_t r);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 14);
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  initial begin
    mlft_pkg::req_t             directed[$];
    logic [mlft_pkg::MAC_W-1:0] seen_src[$];
    logic [63:0]                wide;
    logic [mlft_pkg::MAC_W-1:0] src;
    logic [mlft_pkg::MAC_W-1:0] dst;
    int                         pick;
    logic [mlft_pkg::MAC_W-1:0] mac_a;
    logic [mlft_pkg::MAC_W-1:0] mac_b;
    logic [mlft_pkg::MAC_W-1:0] mac_c;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    mac_a = 48'h02_00_00_00_00_0a;
    mac_b = 48'h02_00_00_00_00_0b;
    mac_c = 48'hfe_dc_ba_98_76_54;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed.push_back(frame(mlft_pkg::BCAST_MAC, mac_a, 32'h0, 16'h0));
    directed.push_back(frame(mac_b, mac_b, 32'hffff_ffff, 16'hffff));
    directed.push_back(frame(mac_a, mac_c, 32'h0a00_0001, 16'd4789));
    directed.push_back(frame(48'h00_11_22_33_44_55, mac_c, 32'h0a00_0002, 16'h0001));
    directed.push_back(frame(mlft_pkg::BCAST_MAC, mac_a, 32'hc0a8_0101, 16'h8000));
    directed.push_back(frame(48'h0, mlft_pkg::BCAST_MAC, 32'h8000_0000, 16'h0001));
    directed.push_back(frame(mlft_pkg::BCAST_MAC, 48'h0, 32'h7fff_ffff, 16'h7fff));
    directed.push_back(frame(48'h0, 48'h8000_0000_0000, 32'h0000_0001, 16'hfffe));
    directed.push_back(frame(mlft_pkg::BCAST_MAC, mlft_pkg::BCAST_MAC, 32'h5555_5555,
                             16'haaaa));
    directed.push_back(frame(mlft_pkg::BCAST_MAC, 48'h7fff_ffff_ffff, 32'haaaa_aaaa,
                             16'h5555));
    directed.push_back(frame(48'hffff_ffff_fffe, mac_a, 32'h0, 16'h0));
    directed.push_back(frame(mac_c, mac_c, 32'hffff_ffff, 16'h0));
    directed.push_back(frame(48'h7fff_ffff_ffff, mac_b, 32'h1234_5678, 16'h9abc));
    foreach (directed[k]) begin
      send_frame(directed[k]);
      seen_src.push_back(directed[k].src_mac);
    end

    // New sources make up most frames so the table fills up and later frames
    // exercise refused learning and full-width floods.
    for (int i = 0; i < RANDOM_FRAMES; i++) begin
      calm = (i >= RANDOM_FRAMES - CALM_FRAMES);
      if ($urandom_range(0, 9) < 6) begin
        wide = {$urandom(), $urandom()};
        src = wide[mlft_pkg::MAC_W-1:0];
        seen_src.push_back(src);
      end else begin
        src = seen_src[$urandom_range(0, seen_src.size() - 1)];
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        dst = mlft_pkg::BCAST_MAC;
      end else if (pick < 70) begin
        dst = seen_src[$urandom_range(0, seen_src.size() - 1)];
      end else if (pick < 80) begin
        dst = src;
      end else begin
        wide = {$urandom(), $urandom()};
        dst = wide[mlft_pkg::MAC_W-1:0];
      end
      send_frame(frame(dst, src, $urandom(), 16'($urandom_range(0, 65535))));
    end
    @(negedge clk);
    req_valid = 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    $display("summary: %0d frames, %0d responses checked, %0d floods, %0d refused learns",
             sb.frames, sb.checked, sb.floods, sb.refused);
    $display("summary: %0d stations stored, %0d cycles", sb.station_count, cycles);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/mlft_pkg.sv
hdl/mlft_cell.sv
hdl/mlft_ring.sv
hdl/mac_learning_forwarding_table_unit.sv
hdl/mlft_checker.sv
tb/tb.sv
